### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the triangle unit normal RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TUN_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TUN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Fixed widths, register map codes and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;
    localparam int EPS_W    = 50;
    localparam int EPS_H    = 25;
    localparam int EPS2_W   = 2 * EPS_W;
    localparam int OUT_W    = 32;
    localparam int OUT_FRAC = 30;
    localparam int Y_W      = OUT_FRAC + 2;
    localparam int R_SHIFT  = 2 * OUT_FRAC + 2;
    localparam int REG_W    = 64;
    localparam int ADDR_W   = 4;

    localparam logic [EPS_W-1:0] EPS_RESET = 50'd17;
    localparam logic REG_IDX_EPSILON = 1'b0;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } t_result;
endpackage

`default_nettype wire

### rtl/core/tun_front.sv
// ----------------------------------------------------------------------------
// Triangle unit normal front end
// Edges, exact cross product, squared norm and the degenerate test.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_front #(
    parameter int CW  = 24,
    parameter int MW  = 2 * CW + 1,
    parameter int SQW = 2 * MW,
    parameter int SW  = SQW + 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic [8:0][CW-1:0]       i_vtx,
    input  wire logic [tun_pkg::EPS_W-1:0] i_eps,
    output logic                          o_valid,
    output logic [SW-1:0]                 o_s,
    output logic [2:0][SQW-1:0]           o_sq,
    output logic [2:0]                    o_neg,
    output logic                          o_deg
);
    import tun_pkg::*;

    localparam int EW   = CW + 1;
    localparam int NW   = 2 * EW;
    localparam int HW   = (MW + 1) / 2;
    localparam int GW   = MW - HW;
    localparam int CMPW = (SW > EPS2_W) ? SW : EPS2_W;

    logic [7:0] r_v;

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [NW-1:0] r_p  [6];
    logic signed [NW-1:0] r_n  [3];
    logic [MW-1:0]        r_m  [3];
    logic [2:0]           r_neg4, r_neg5, r_neg6, r_neg7, r_neg8;
    logic [2*GW-1:0]      r_hh [3];
    logic [GW+HW-1:0]     r_hl [3];
    logic [2*HW-1:0]      r_ll [3];
    logic [2:0][SQW-1:0]  r_sq6, r_sq7, r_sq8;
    logic [SW-1:0]        r_s7, r_s8;
    logic                 r_deg8;

    logic [EPS_H-1:0]         w_eh, w_el;
    logic [2*EPS_H-1:0]       r_ehh, r_ehl, r_ell;
    logic [EPS2_W-1:0]        r_eps2;
    logic signed [NW-1:0]     w_abs [3];

    assign w_eh = i_eps[EPS_W-1:EPS_H];
    assign w_el = i_eps[EPS_H-1:0];

    always_ff @(posedge i_clk) begin
        r_ehh  <= w_eh * w_eh;
        r_ehl  <= w_eh * w_el;
        r_ell  <= w_el * w_el;
        r_eps2 <= (EPS2_W'(r_ehh) << (2 * EPS_H)) + (EPS2_W'(r_ehl) << (EPS_H + 1))
                + EPS2_W'(r_ell);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = r_n[i][NW-1] ? -r_n[i] : r_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= EW'(signed'(i_vtx[3+i])) - EW'(signed'(i_vtx[i]));
                r_e2[i] <= EW'(signed'(i_vtx[6+i])) - EW'(signed'(i_vtx[i]));
            end
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            for (int i = 0; i < 3; i++) begin
                r_n[i]    <= r_p[2*i] - r_p[2*i+1];
                r_neg4[i] <= r_n[i][NW-1];
                r_m[i]    <= MW'(w_abs[i]);
                r_hh[i]   <= r_m[i][MW-1:HW] * r_m[i][MW-1:HW];
                r_hl[i]   <= r_m[i][MW-1:HW] * r_m[i][HW-1:0];
                r_ll[i]   <= r_m[i][HW-1:0] * r_m[i][HW-1:0];
                r_sq6[i]  <= (SQW'(r_hh[i]) << (2 * HW)) + (SQW'(r_hl[i]) << (HW + 1))
                           + SQW'(r_ll[i]);
            end
            r_neg5 <= r_neg4;
            r_neg6 <= r_neg5;
            r_neg7 <= r_neg6;
            r_neg8 <= r_neg7;
            r_sq7  <= r_sq6;
            r_sq8  <= r_sq7;
            r_s7   <= SW'(r_sq6[0]) + SW'(r_sq6[1]) + SW'(r_sq6[2]);
            r_s8   <= r_s7;
            r_deg8 <= (r_s7 == '0) || (CMPW'(r_s7) < CMPW'(r_eps2));
        end
    end

    assign o_valid = r_v[7];
    assign o_s     = r_s8;
    assign o_sq    = r_sq8;
    assign o_neg   = r_neg8;
    assign o_deg   = r_deg8;
endmodule

`default_nettype wire

### rtl/core/tun_root.sv
// ----------------------------------------------------------------------------
// Triangle unit normal root pipeline
// One stage per quotient bit of floor(2^31 |n_i| / |n|), then rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_root #(
    parameter int SQW = 98,
    parameter int SW  = SQW + 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [SW-1:0]        i_s,
    input  wire logic [2:0][SQW-1:0]  i_sq,
    input  wire logic [2:0]           i_neg,
    input  wire logic                 i_deg,
    output logic                      o_valid,
    output tun_pkg::t_result          o_res
);
    import tun_pkg::*;

    localparam int DW = SW + 65;

    logic [DW-1:0]  w_d   [Y_W+1][3];
    logic [DW-1:0]  w_b   [Y_W+1][3];
    logic [Y_W-1:0] w_y   [Y_W+1][3];
    logic [SW-1:0]  w_s   [Y_W+1];
    logic           w_v   [Y_W+1];
    logic [2:0]     w_neg [Y_W+1];
    logic           w_deg [Y_W+1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[0][i] = DW'(i_sq[i]) << R_SHIFT;
            w_b[0][i] = '0;
            w_y[0][i] = '0;
        end
    end
    assign w_s[0]   = i_s;
    assign w_v[0]   = i_valid;
    assign w_neg[0] = i_neg;
    assign w_deg[0] = i_deg;

    for (genvar j = 0; j < Y_W; j++) begin : g_step
        localparam int K = Y_W - 1 - j;

        logic [DW-1:0]  n_d [3];
        logic [DW-1:0]  n_b [3];
        logic [Y_W-1:0] n_y [3];
        logic [DW-1:0]  r_d [3];
        logic [DW-1:0]  r_b [3];
        logic [Y_W-1:0] r_y [3];
        logic [SW-1:0]  r_s;
        logic           r_v;
        logic [2:0]     r_neg;
        logic           r_deg;

        always_comb begin
            logic [DW-1:0] t;
            logic          fit;
            for (int i = 0; i < 3; i++) begin
                t   = (w_b[j][i] << (K + 1)) + (DW'(w_s[j]) << (2 * K));
                fit = (t <= w_d[j][i]);
                n_d[i] = fit ? (w_d[j][i] - t) : w_d[j][i];
                n_b[i] = fit ? (w_b[j][i] + (DW'(w_s[j]) << K)) : w_b[j][i];
                n_y[i] = fit ? (w_y[j][i] | (Y_W'(1) << K)) : w_y[j][i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d   <= n_d;
                r_b   <= n_b;
                r_y   <= n_y;
                r_s   <= w_s[j];
                r_neg <= w_neg[j];
                r_deg <= w_deg[j];
            end
        end

        assign w_d[j+1]   = r_d;
        assign w_b[j+1]   = r_b;
        assign w_y[j+1]   = r_y;
        assign w_s[j+1]   = r_s;
        assign w_v[j+1]   = r_v;
        assign w_neg[j+1] = r_neg;
        assign w_deg[j+1] = r_deg;
    end

    logic                    r_v;
    t_result                 r_res;
    logic signed [OUT_W-1:0] w_c [3];

    always_comb begin
        logic [Y_W:0]     yp;
        logic [OUT_W-1:0] lo;
        for (int i = 0; i < 3; i++) begin
            yp     = {1'b0, w_y[Y_W][i]} + (Y_W+1)'(1);
            lo     = OUT_W'(yp[Y_W:1]);
            w_c[i] = w_deg[Y_W] ? '0 : (w_neg[Y_W][i] ? -signed'(lo) : signed'(lo));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= w_v[Y_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.normal_x   <= w_c[0];
            r_res.normal_y   <= w_c[1];
            r_res.normal_z   <= w_c[2];
            r_res.degenerate <= w_deg[Y_W];
        end
    end

    assign o_valid = r_v;
    assign o_res   = r_res;
endmodule

`default_nettype wire

### rtl/core/tun_out.sv
// ----------------------------------------------------------------------------
// Triangle unit normal output stage
// Output register with a skid entry; holds the pipeline while the skid is full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tun_out (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire tun_pkg::t_result  i_res,
    output logic                   o_en,
    output logic                   o_valid,
    output tun_pkg::t_result       o_res,
    input  wire logic              i_ready
);
    import tun_pkg::*;

    logic    r_ov, r_sv;
    t_result r_res, r_skid;
    logic    w_in_v;

    assign o_en   = !r_sv;
    assign w_in_v = i_valid && !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_in_v;
            end
        end else if (w_in_v) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_ready) begin
            r_res <= r_sv ? r_skid : i_res;
        end else if (w_in_v) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

    `TUN_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_sv, r_ov)
    `TUN_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_sv && i_ready, !r_sv)
    `TUN_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, w_in_v && r_ov && !i_ready, r_sv)
    `TUN_ASSERT_SAME(a_degenerate_zero, i_clk, i_rst_n, r_ov && r_res.degenerate,
        r_res.normal_x == '0 && r_res.normal_y == '0 && r_res.normal_z == '0)
endmodule

`default_nettype wire

### rtl/core/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// Triangle unit normal
// Unit face normal in Q1.30 of a triangle given as three fixed-point vertices.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  input    | in        | i_valid / o_ready  | i_a_x .. i_c_z
//  output   | out       | o_valid / i_ready  | o_normal_x/y/z, o_degenerate
//  config   | in        | APB psel/penable   | epsilon at byte address 0
//
// One beat is accepted per cycle while the skid entry is empty. A beat passes
// through eight front-end stages, one stage per bit of the 32-bit root
// quotient, a rounding stage and the output register.
// Reset is synchronous and clears all valid bits and sets epsilon to 17.
// A stalled output fills a single skid entry, which then holds the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_unit_normal #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [COORD_BITS-1:0]      i_a_x,
    input  wire logic signed [COORD_BITS-1:0]      i_a_y,
    input  wire logic signed [COORD_BITS-1:0]      i_a_z,
    input  wire logic signed [COORD_BITS-1:0]      i_b_x,
    input  wire logic signed [COORD_BITS-1:0]      i_b_y,
    input  wire logic signed [COORD_BITS-1:0]      i_b_z,
    input  wire logic signed [COORD_BITS-1:0]      i_c_x,
    input  wire logic signed [COORD_BITS-1:0]      i_c_y,
    input  wire logic signed [COORD_BITS-1:0]      i_c_z,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [tun_pkg::OUT_W-1:0]       o_normal_x,
    output logic signed [tun_pkg::OUT_W-1:0]       o_normal_y,
    output logic signed [tun_pkg::OUT_W-1:0]       o_normal_z,
    output logic                                   o_degenerate,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tun_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [tun_pkg::REG_W-1:0]         pwdata,
    output logic [tun_pkg::REG_W-1:0]              prdata,
    output logic                                   pready
);
    import tun_pkg::*;

    localparam int MW  = 2 * COORD_BITS + 1;
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;

    logic [EPS_W-1:0]          r_eps;
    logic [8:0][COORD_BITS-1:0] w_vtx;
    logic                      w_en;
    logic                      w_f_v, w_deg, w_r_v;
    logic [SW-1:0]             w_s;
    logic [2:0][SQW-1:0]       w_sq;
    logic [2:0]                w_neg;
    t_result                   w_r_res, w_o_res;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_IDX_EPSILON) ? REG_W'(r_eps) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[3] == REG_IDX_EPSILON) begin
            r_eps <= pwdata[EPS_W-1:0];
        end
    end

    assign w_vtx = {i_c_z, i_c_y, i_c_x, i_b_z, i_b_y, i_b_x, i_a_z, i_a_y, i_a_x};
    assign o_ready = w_en;

    tun_front #(
        .CW  (COORD_BITS),
        .MW  (MW),
        .SQW (SQW),
        .SW  (SW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_vtx   (w_vtx),
        .i_eps   (r_eps),
        .o_valid (w_f_v),
        .o_s     (w_s),
        .o_sq    (w_sq),
        .o_neg   (w_neg),
        .o_deg   (w_deg)
    );

    tun_root #(
        .SQW (SQW),
        .SW  (SW)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_s     (w_s),
        .i_sq    (w_sq),
        .i_neg   (w_neg),
        .i_deg   (w_deg),
        .o_valid (w_r_v),
        .o_res   (w_r_res)
    );

    tun_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_r_v),
        .i_res   (w_r_res),
        .o_en    (w_en),
        .o_valid (o_valid),
        .o_res   (w_o_res),
        .i_ready (i_ready)
    );

    assign o_normal_x   = w_o_res.normal_x;
    assign o_normal_y   = w_o_res.normal_y;
    assign o_normal_z   = w_o_res.normal_z;
    assign o_degenerate = w_o_res.degenerate;
endmodule

`default_nettype wire

### verif/tb_triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Drives triangles through the valid/ready input, predicts each unit normal
// with exact wide integer arithmetic and checks every output beat in order.
// The epsilon register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

class normal_scoreboard;
    tun_pkg::t_result pending_normals[$];
    int mismatches;
    int failed;

    function new();
        mismatches = 0;
        failed = 0;
    endfunction

    function void note_triangle(tun_pkg::t_result r);
        pending_normals.push_back(r);
    endfunction

    function void check_normal(tun_pkg::t_result got);
        tun_pkg::t_result want;
        if (pending_normals.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected normal beat %h", got);
            return;
        end
        want = pending_normals.pop_front();
        if (got !== want) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: exp x=%0d y=%0d z=%0d d=%0b got x=%0d y=%0d z=%0d d=%0b",
                    want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                    got.normal_x, got.normal_y, got.normal_z, got.degenerate);
        end
    endfunction
endclass

module tb_triangle_unit_normal;
    import tun_pkg::*;

    typedef logic signed [23:0] t_coord;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_coord i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z;
    logic o_valid;
    logic i_ready;
    logic signed [OUT_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [REG_W-1:0] pwdata;
    logic [REG_W-1:0] prdata;
    logic pready;

    normal_scoreboard board;
    logic [EPS_W-1:0] eps_model;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;

    triangle_unit_normal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_c_z(i_c_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_degenerate(o_degenerate),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    // Nearest Q1.30 value of comp / sqrt(sumsq), ties away from zero.
    function automatic logic signed [OUT_W-1:0] unit_component(
            logic signed [63:0] comp, logic [255:0] sumsq);
        logic [255:0] mag;
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] t;
        mag = comp < 0 ? 256'(-comp) : 256'(comp);
        rhs = (mag * mag) << R_SHIFT;
        lo = 0;
        hi = 64'd1 << OUT_FRAC;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            lhs = 256'(t) * 256'(t) * sumsq;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return comp < 0 ? -OUT_W'(lo) : OUT_W'(lo);
    endfunction

    function automatic t_result predict_normal(t_coord v[9]);
        logic signed [63:0] e1[3];
        logic signed [63:0] e2[3];
        logic signed [63:0] n[3];
        logic [255:0] sumsq;
        logic [255:0] eps_sq;
        t_result r;
        for (int i = 0; i < 3; i++) begin
            e1[i] = 64'(v[3+i]) - 64'(v[i]);
            e2[i] = 64'(v[6+i]) - 64'(v[i]);
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        sumsq = 0;
        for (int i = 0; i < 3; i++) sumsq += 256'(n[i]) * 256'(n[i]);
        eps_sq = 256'(eps_model) * 256'(eps_model);
        r = '0;
        if (sumsq == 0 || sumsq < eps_sq) begin
            r.degenerate = 1'b1;
        end else begin
            r.normal_x = unit_component(n[0], sumsq);
            r.normal_y = unit_component(n[1], sumsq);
            r.normal_z = unit_component(n[2], sumsq);
        end
        return r;
    endfunction

    task automatic write_epsilon(logic [EPS_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_IDX_EPSILON, 3'b000};
        pwdata <= REG_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        eps_model = value;
    endtask

    task automatic send_triangle(t_coord v[9]);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} <=
            {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_triangle(predict_normal(v));
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (board.pending_normals.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(64, 0)) - 32;
            2: return $urandom_range(1, 0) ? 24'sh7fffff : 24'sh800000;
            default: return t_coord'($urandom_range(8191, 0)) - 4096;
        endcase
    endfunction

    task automatic send_random(int count);
        t_coord v[9];
        int mode;
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(3, 0);
            for (int i = 0; i < 9; i++) v[i] = rand_coord(mode == 2 ? $urandom_range(2, 0) : mode);
            if ($urandom_range(19, 0) == 0) begin
                // Collinear or repeated vertices give a zero cross product.
                for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
            end
            send_triangle(v);
        end
    endtask

    // Output side: samples at the edge, drives ready with nonblocking updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_normal({o_normal_x, o_normal_y, o_normal_z, o_degenerate});
        if (recv_hold) i_ready <= 1'b0;
        else i_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end

    initial begin
        t_coord v[9];
        logic [EPS_W-1:0] eps_max;
        int waited;
        board = new();
        eps_max = '1;
        eps_model = EPS_RESET;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 17;
        recv_idle_pct = 51;
        recv_hold = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed triangles at the reset epsilon.
        for (int i = 0; i < 9; i++) v[i] = 0;
        send_triangle(v);
        v[3] = 24'sd4096; v[7] = 24'sd4096;
        send_triangle(v);
        for (int i = 0; i < 9; i++) v[i] = 0;
        v[4] = 24'sd1; v[8] = 24'sd1;
        send_triangle(v);
        v[4] = 24'sd5; v[8] = 24'sd4;
        send_triangle(v);
        for (int i = 0; i < 9; i++) v[i] = 24'sh800000;
        v[3] = 24'sh7fffff; v[7] = 24'sh7fffff;
        send_triangle(v);
        for (int i = 0; i < 9; i++) v[i] = (i % 2) ? 24'sh7fffff : 24'sh800000;
        send_triangle(v);
        for (int i = 0; i < 9; i++) v[i] = 0;
        v[3] = 24'sd3; v[4] = 24'sd4; v[6] = -24'sd4; v[7] = 24'sd3; v[8] = 24'sd7;
        send_triangle(v);
        for (int i = 0; i < 9; i++) v[i] = 24'sd100;
        v[3] = 24'sd200; v[6] = 24'sd300;
        send_triangle(v);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 9; j++) v[j] = 0;
            v[3 + i] = 24'sh7fffff;
            v[6 + (i + 1) % 3] = 24'sh800000;
            send_triangle(v);
        end
        drain_and_settle();

        write_epsilon('0);
        for (int i = 0; i < 9; i++) v[i] = 0;
        send_triangle(v);
        v[4] = 24'sd1; v[8] = 24'sd1;
        send_triangle(v);
        send_random(300);
        drain_and_settle();

        send_idle_pct = 17;
        recv_idle_pct = 51;
        write_epsilon(50'd1 << 24);
        send_random(500);
        drain_and_settle();

        send_idle_pct = 51;
        recv_idle_pct = 17;
        write_epsilon(eps_max);
        for (int i = 0; i < 9; i++) v[i] = (i % 2) ? 24'sh7fffff : 24'sh800000;
        send_triangle(v);
        send_random(100);
        drain_and_settle();

        write_epsilon(50'($urandom_range(1 << 20, 0)) << $urandom_range(28, 0));
        send_random(400);
        drain_and_settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_epsilon(EPS_RESET);
        recv_hold <= 1'b1;
        fork
            send_random(120);
            begin
                waited = 0;
                while (waited < 300) begin
                    @(posedge i_clk);
                    waited++;
                end
                recv_hold <= 1'b0;
            end
        join
        send_random(480);
        drain_and_settle();

        if (board.failed == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/tun_pkg.sv
rtl/core/tun_front.sv
rtl/core/tun_root.sv
rtl/core/tun_out.sv
rtl/core/triangle_unit_normal.sv
verif/tb_triangle_unit_normal.sv
